>>> sv/pal_pkg.sv
package pal_pkg;

  localparam int CAPACITY  = 128;
  localparam int WORD_BITS = 32;

  // count must hold CAPACITY itself; indexes also hold position + 1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = (CNT_W > 9) ? CNT_W : 9;

  // cells per reduction group and number of groups
  localparam int GRP_SIZE = (CAPACITY <= 256) ? 16 : 64;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GL_W     = $clog2(GRP_SIZE);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IW-1:0]        idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [GL_W-1:0]      gidx_t;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_SEARCH = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_WRITE  = 3'd4;
  localparam logic [2:0] KIND_APPEND = 3'd5;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // broadcast to every cell while matching / selecting
  typedef struct packed {
    word_t val;
    idx_t  sel;
    idx_t  cnt;
  } probe_t;

  // broadcast to every cell when an operation commits
  typedef struct packed {
    logic  en;
    logic  up;
    logic  dn;
    logic  ld;
    logic  clr;
    idx_t  lo;
    idx_t  hi;
    idx_t  ld_idx;
    idx_t  clr_idx;
    word_t val;
  } upd_t;

endpackage

>>> sv/pal_cell.sv
module pal_cell (
  input  logic            clk_i,
  input  pal_pkg::idx_t   idx_i,
  input  pal_pkg::word_t  lower_i,
  input  pal_pkg::word_t  upper_i,
  input  pal_pkg::probe_t probe_i,
  input  pal_pkg::upd_t   upd_i,
  output logic            hit_o,
  output logic            sel_o,
  output pal_pkg::word_t  entry_o
);
  import pal_pkg::*;

  word_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (upd_i.en) begin
      if (upd_i.ld && idx_i == upd_i.ld_idx) begin
        entry_d = upd_i.val;
      end else if (upd_i.clr && idx_i == upd_i.clr_idx) begin
        entry_d = '0;
      end else if (upd_i.up && idx_i > upd_i.lo && idx_i <= upd_i.hi) begin
        entry_d = lower_i;
      end else if (upd_i.dn && idx_i >= upd_i.lo && idx_i < upd_i.hi) begin
        entry_d = upper_i;
      end
    end
  end

  // slots above the fill level are never observed, so no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign hit_o   = (entry_q == probe_i.val) && (idx_i < probe_i.cnt);
  assign sel_o   = (idx_i == probe_i.sel);
  assign entry_o = entry_q;

endmodule

>>> sv/pal_group.sv
module pal_group (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           hit_i  [pal_pkg::GRP_SIZE],
  input  logic           sel_i  [pal_pkg::GRP_SIZE],
  input  pal_pkg::word_t word_i [pal_pkg::GRP_SIZE],
  output logic           any_o,
  output pal_pkg::gidx_t first_o,
  output pal_pkg::word_t data_o
);
  import pal_pkg::*;

  logic  any_d, any_q;
  gidx_t first_d, first_q;
  word_t data_d, data_q;

  always_comb begin
    any_d   = 1'b0;
    first_d = '0;
    data_d  = '0;
    // lowest hit wins
    for (int j = GRP_SIZE - 1; j >= 0; j--) begin
      if (hit_i[j]) begin
        any_d   = 1'b1;
        first_d = GL_W'(j);
      end
    end
    for (int j = 0; j < GRP_SIZE; j++) begin
      data_d = data_d | (word_i[j] & {WORD_BITS{sel_i[j]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      any_q   <= any_d;
      first_q <= first_d;
      data_q  <= data_d;
    end
  end

  assign any_o   = any_q;
  assign first_o = first_q;
  assign data_o  = data_q;

endmodule

>>> sv/positional_array_list_unit.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------------
// request  | in        | in_valid_i / in_stall_o  | kind_i, position_i, value_i
// result   | out       | out_valid_o / out_stall_i| data_out_o, match_index_o,
//          |           |                         | status_o, count_o, is_empty_o
//
// Each request passes accept, then the per-group match/select registers,
// then the commit that combines the groups, shifts the cell row and loads
// the result register; no new request is taken until it commits.
// The commit waits only while an earlier result is still stalled; a new
// request is taken while a finished result waits.
// Reset clears the fill count, the state and the result valid; cell contents
// above the fill count are never observed and are not reset.
module positional_array_list_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] data_out_o,
  output logic [7:0]  match_index_o,
  output logic [1:0]  status_o,
  output logic [7:0]  count_o,
  output logic        is_empty_o
);
  import pal_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   out_valid_q, out_valid_d;

  // latched request
  logic [2:0] kind_q;
  logic [7:0] pos_q;
  word_t      val_q;

  // result register
  logic [31:0] data_q;
  logic [7:0]  match_q;
  status_e     status_q;
  logic [7:0]  cnt_out_q;
  logic        empty_q;

  logic [63:0] val_wide;
  logic        accept;
  logic        commit;

  assign val_wide   = 64'(value_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------- cell row
  probe_t probe;
  upd_t   upd;
  word_t  entry [CAPACITY];
  word_t  lower [CAPACITY];
  word_t  upper [CAPACITY];
  logic   hit   [CAPACITY];
  logic   sel   [CAPACITY];

  idx_t cnt_w, pos_w;
  assign cnt_w = IW'(count_q);
  assign pos_w = IW'(pos_q);

  always_comb begin
    probe.val = val_q;
    probe.cnt = cnt_w;
    // delete picks a 0-based slot, read a 1-based one
    probe.sel = (kind_q == KIND_DELETE) ? pos_w : (pos_w - IW'(1));
  end

  always_comb begin
    lower[0]            = '0;
    upper[CAPACITY - 1] = '0;
    for (int k = 1; k < CAPACITY; k++) begin
      lower[k]     = entry[k - 1];
      upper[k - 1] = entry[k];
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    pal_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IW'(k)),
      .lower_i (lower[k]),
      .upper_i (upper[k]),
      .probe_i (probe),
      .upd_i   (upd),
      .hit_o   (hit[k]),
      .sel_o   (sel[k]),
      .entry_o (entry[k])
    );
  end

  // ------------------------------------------------------ reduction groups
  logic  g_any   [NGRP];
  gidx_t g_first [NGRP];
  word_t g_data  [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic  hit_g  [GRP_SIZE];
    logic  sel_g  [GRP_SIZE];
    word_t word_g [GRP_SIZE];

    always_comb begin
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          hit_g[j]  = hit[g * GRP_SIZE + j];
          sel_g[j]  = sel[g * GRP_SIZE + j];
          word_g[j] = entry[g * GRP_SIZE + j];
        end else begin
          hit_g[j]  = 1'b0;
          sel_g[j]  = 1'b0;
          word_g[j] = '0;
        end
      end
    end

    pal_group u_group (
      .clk_i   (clk_i),
      .en_i    (state_q == ST_SCAN),
      .hit_i   (hit_g),
      .sel_i   (sel_g),
      .word_i  (word_g),
      .any_o   (g_any[g]),
      .first_o (g_first[g]),
      .data_o  (g_data[g])
    );
  end

  // combine groups: first matching group wins, select data is one-hot
  idx_t  match_pos;
  word_t sel_data;

  always_comb begin
    match_pos = '0;
    sel_data  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        match_pos = IW'(g * GRP_SIZE) + IW'(g_first[g]) + IW'(1);
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      sel_data = sel_data | g_data[g];
    end
  end

  // ------------------------------------------------------------ operation
  logic        full;
  idx_t        slot;
  status_e     status_d;
  word_t       data_w;
  idx_t        match_d;
  logic [63:0] data_wide;

  assign full = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    upd      = '0;
    upd.val  = val_q;
    status_d = STAT_DONE;
    data_w   = '0;
    match_d  = '0;
    count_d  = count_q;
    slot     = (pos_w + IW'(1) > cnt_w) ? cnt_w : (pos_w + IW'(1));

    case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          upd.ld  = 1'b1;
          count_d = count_q + CNT_W'(1);
          if (count_q == '0) begin
            upd.ld_idx = '0;
          end else begin
            upd.ld_idx = slot;
            upd.up     = 1'b1;
            upd.lo     = slot;
            upd.hi     = cnt_w;
          end
        end
      end
      KIND_DELETE: begin
        if (count_q == '0 || pos_w >= cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          data_w      = sel_data;
          upd.dn      = 1'b1;
          upd.lo      = pos_w;
          upd.hi      = cnt_w - IW'(1);
          upd.clr     = 1'b1;
          upd.clr_idx = cnt_w - IW'(1);
          count_d     = count_q - CNT_W'(1);
        end
      end
      KIND_SEARCH: begin
        match_d = match_pos;
      end
      KIND_READ: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          data_w = sel_data;
        end
      end
      KIND_WRITE: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          upd.ld     = 1'b1;
          upd.ld_idx = pos_w - IW'(1);
        end
      end
      KIND_APPEND: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          upd.ld     = 1'b1;
          upd.ld_idx = cnt_w;
          count_d    = count_q + CNT_W'(1);
        end
      end
      default: begin
        // unused kinds leave everything alone
      end
    endcase

    upd.en = commit;
    if (!commit) begin
      count_d = count_q;
    end
  end

  assign data_wide = 64'(data_w);

  // ------------------------------------------------------------ control
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= val_wide[WORD_BITS-1:0];
    end
    if (commit) begin
      data_q    <= data_wide[31:0];
      match_q   <= match_d[7:0];
      status_q  <= status_d;
      cnt_out_q <= 8'(count_d);
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_o    = data_q;
  assign match_index_o = match_q;
  assign status_o      = status_q;
  assign count_o       = cnt_out_q;
  assign is_empty_o    = empty_q;

endmodule

>>> tb/sv/pal_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list unit, keeps a shadow copy of the list,
// and compares each result with the oldest outstanding prediction.
module pal_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] value_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [31:0] data_out_i,
  input  logic [7:0]  match_index_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  count_i,
  input  logic        is_empty_i,
  output int          errors_o,
  output int          pending_o
);
  import pal_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    word_t      data;
    logic [7:0] match;
    status_e    status;
    logic [7:0] count;
    logic       empty;
  } list_outcome_t;

  // shadow list
  word_t         cells [CAPACITY];
  int            fill;
  list_outcome_t expected_outcomes [$];

  // applies one request to the shadow list, returns the result it should give
  function automatic list_outcome_t apply_list_op(input logic [2:0] kind,
                                                  input logic [7:0] pos,
                                                  input word_t val);
    list_outcome_t o;
    int            slot;
    int            i;
    o = '0;
    o.status = STAT_DONE;
    case (kind)
      KIND_INSERT: begin
        if (fill >= CAPACITY) begin
          o.status = STAT_FULL;
        end else if (fill == 0) begin
          cells[0] = val;
          fill = 1;
        end else begin
          // past the end means append
          slot = int'(pos) + 1;
          if (slot > fill) slot = fill;
          for (i = fill; i > slot; i--) cells[i] = cells[i-1];
          cells[slot] = val;
          fill++;
        end
      end
      KIND_DELETE: begin
        if (fill == 0 || int'(pos) >= fill) begin
          o.status = STAT_RANGE;
        end else begin
          o.data = cells[pos];
          for (i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
          cells[fill-1] = '0;
          fill--;
        end
      end
      KIND_SEARCH: begin
        for (i = 0; i < fill; i++) begin
          if (cells[i] == val) begin
            o.match = 8'(i + 1);
            break;
          end
        end
      end
      KIND_READ: begin
        if (pos == 0 || int'(pos) > fill) o.status = STAT_RANGE;
        else o.data = cells[pos-1];
      end
      KIND_WRITE: begin
        if (pos == 0 || int'(pos) > fill) o.status = STAT_RANGE;
        else cells[pos-1] = val;
      end
      KIND_APPEND: begin
        if (fill >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          cells[fill] = val;
          fill++;
        end
      end
      default: begin
      end
    endcase
    o.count = 8'(fill);
    o.empty = (fill == 0);
    return o;
  endfunction

  always @(posedge clk_i) begin
    list_outcome_t got;
    list_outcome_t want;
    list_outcome_t predicted;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) cells[i] = '0;
      fill = 0;
      expected_outcomes.delete();
    end else begin
      if (res_valid_i && !res_stall_i) begin
        got.data   = data_out_i;
        got.match  = match_index_i;
        got.status = status_e'(status_i);
        got.count  = count_i;
        got.empty  = is_empty_i;
        if (expected_outcomes.size() == 0) begin
          if (errors_o < MAX_REPORTS)
            $display("%0t: result with no request outstanding: data %h count %0d",
                     $time, got.data, got.count);
          errors_o++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            if (errors_o < MAX_REPORTS) begin
              $write("%0t: result mismatch (exp/act) data %h/%h match %0d/%0d ",
                     $time, want.data, got.data, want.match, got.match);
              $display("status %0d/%0d count %0d/%0d empty %b/%b",
                       want.status, got.status, want.count, got.count,
                       want.empty, got.empty);
            end
            errors_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        predicted = apply_list_op(kind_i, position_i, value_i[WORD_BITS-1:0]);
        expected_outcomes = {expected_outcomes, predicted};
      end
    end
    pending_o = expected_outcomes.size();
  end

endmodule

>>> tb/sv/tb_positional_array_list_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the positional array list unit.
// The checker beside the block does all prediction; this module only makes
// requests, stalls the result side and decides pass/fail at the end.
module tb_positional_array_list_unit;
  import pal_pkg::*;

  // kinds the block decodes as no-ops
  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 830;
  localparam int QUIET_LIMIT     = 2000;   // cycles with no handshake at all
  localparam int TAIL_CYCLES     = 12;
  localparam int RUN_CAP         = 300;

  // how a random request should move the list length
  typedef enum int {
    STEER_ANY,
    STEER_GROW,
    STEER_SHRINK
  } steer_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i       = '0;
  logic [7:0]  position_i   = '0;
  logic [31:0] value_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] data_out_o;
  logic [7:0]  match_index_o;
  logic [1:0]  status_o;
  logic [7:0]  count_o;
  logic        is_empty_o;

  int          mismatches;
  int          outcomes_pending;

  // stimulus-side bookkeeping
  logic        req_taken    = 1'b0;
  int          quiet_cycles = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          fill_est     = 0;   // list length as the stimulus sees it
  int          requests_sent = 0;
  int          full_rejects = 0;
  int          empty_visits = 0;
  word_t       value_pool [8];

  positional_array_list_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_out_o    (data_out_o),
    .match_index_o (match_index_o),
    .status_o      (status_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o)
  );

  pal_list_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_stall_i   (in_stall_o),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .res_valid_i   (out_valid_o),
    .res_stall_i   (out_stall_i),
    .data_out_i    (data_out_o),
    .match_index_i (match_index_o),
    .status_i      (status_o),
    .count_i       (count_o),
    .is_empty_i    (is_empty_o),
    .errors_o      (mismatches),
    .pending_o     (outcomes_pending)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result-side back-pressure, redrawn every falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // req_taken is read by the driver at the next falling edge, so the
  // acceptance decision never races the rising edge.
  // The watchdog ends a run that stops making progress.
  always @(posedge clk_i) begin
    req_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, outcomes_pending);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drives one request and holds it until it is taken. Entered and left at a
  // falling edge; the caller always drives in_valid_i again at that edge.
  task automatic send_request(input logic [2:0] kind, input logic [7:0] pos,
                              input word_t val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    position_i <= pos;
    value_i    <= val;
    do @(negedge clk_i); while (!req_taken);
    requests_sent++;
    // length tracking only shapes the stimulus; checking is in the checker
    case (kind)
      KIND_INSERT, KIND_APPEND: begin
        if (fill_est < CAPACITY) fill_est++;
        else full_rejects++;
      end
      KIND_DELETE: begin
        if (int'(pos) < fill_est) begin
          fill_est--;
          if (fill_est == 0) empty_visits++;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Pressure point: hold the request side until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (outcomes_pending != 0) @(negedge clk_i);
  endtask

  // Positions mostly near the current length so both in-range and the
  // first out-of-range slot get hit; a share spans the whole 8-bit field.
  function automatic logic [7:0] pick_position(input logic [2:0] kind,
                                               input logic in_range);
    if (!in_range && $urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
    case (kind)
      KIND_INSERT: return 8'($urandom_range(0, fill_est));
      KIND_DELETE: begin
        if (in_range && fill_est > 0) return 8'($urandom_range(0, fill_est - 1));
        return 8'($urandom_range(0, fill_est));
      end
      KIND_READ, KIND_WRITE: return 8'($urandom_range(0, fill_est + 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Pool values recur so that searches find matches, duplicates included.
  function automatic word_t pick_value(input logic [2:0] kind);
    int pool_pct;
    pool_pct = (kind == KIND_SEARCH) ? 70 : 40;
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_random(input steer_e steer);
    logic [2:0] kind;
    int         r;
    case (steer)
      STEER_GROW:   kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
      STEER_SHRINK: kind = KIND_DELETE;
      default: begin
        r = $urandom_range(0, 99);
        if      (r < 18) kind = KIND_INSERT;
        else if (r < 36) kind = KIND_DELETE;
        else if (r < 54) kind = KIND_SEARCH;
        else if (r < 70) kind = KIND_READ;
        else if (r < 86) kind = KIND_WRITE;
        else if (r < 96) kind = KIND_APPEND;
        else kind = $urandom_range(0, 1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      end
    endcase
    send_request(kind, pick_position(kind, steer != STEER_ANY), pick_value(kind));
  endtask

  initial begin
    int     phase_end;
    int     random_sent;
    int     target;
    int     extra;
    int     run_len;
    int     r;
    steer_e steer;

    // reset held low, then released on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;

    // ---- directed: empty-list corners, then a short list worked over ----
    send_request(KIND_READ,   8'd1,   32'h0000_0001);  // read of empty list
    send_request(KIND_DELETE, 8'd0,   32'h0);          // delete from empty list
    send_request(KIND_SEARCH, 8'd0,   32'h0);          // search of empty list
    send_request(KIND_WRITE,  8'd1,   32'hDEAD_BEEF);  // write of empty list
    send_request(KIND_INSERT, 8'd200, 32'hFFFF_FFFF);  // empty: lands at slot 0
    send_request(KIND_APPEND, 8'd0,   32'h0000_0000);
    send_request(KIND_INSERT, 8'd0,   32'hA5A5_5A5A);  // middle insert, shifts up
    send_request(KIND_INSERT, 8'd255, 32'h0000_0001);  // past the end: appends
    send_request(KIND_SEARCH, 8'd0,   32'hFFFF_FFFF);  // match at first slot
    send_request(KIND_SEARCH, 8'd0,   32'h0000_0000);  // match deeper in
    send_request(KIND_SEARCH, 8'd0,   32'h1234_5678);  // no match
    send_request(KIND_READ,   8'd0,   32'h0);          // position 0 is invalid
    send_request(KIND_READ,   8'd4,   32'h0);          // last entry
    send_request(KIND_READ,   8'd5,   32'h0);          // one past the end
    send_request(KIND_WRITE,  8'd4,   32'h8000_0000);
    send_request(KIND_WRITE,  8'd0,   32'h7FFF_FFFF);  // position 0 rejected
    send_request(KIND_WRITE,  8'd5,   32'h5555_5555);  // past the end
    send_request(KIND_DELETE, 8'd3,   32'h0);          // last entry
    send_request(KIND_DELETE, 8'd3,   32'h0);          // now out of range
    send_request(KIND_DELETE, 8'd0,   32'h0);          // head, shifts down
    send_request(KIND_UNUSED_LO, 8'hFF, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED_HI, 8'h80, 32'h0F0F_F0F0);
    send_request(KIND_READ,   8'd128, 32'h0);
    send_request(KIND_DELETE, 8'd255, 32'h0);
    drain_results();

    // ---- random: runs that steer the length toward a target ----
    // Four handshake mixes; the first run steers the length toward a full list
    // so the full-list rejections are seen early.
    random_sent = 0;
    target = CAPACITY;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      phase_end = (phase + 1) * RANDOM_REQUESTS / 4;
      while (random_sent < phase_end) begin
        extra   = $urandom_range(2, 8);
        run_len = 0;
        while (extra > 0 && run_len < RUN_CAP) begin
          steer = STEER_ANY;
          if ($urandom_range(0, 99) < 70) begin
            if (fill_est < target) steer = STEER_GROW;
            else if (fill_est > target) steer = STEER_SHRINK;
            else if (target == CAPACITY) steer = STEER_GROW;
            else if (target == 0) steer = STEER_SHRINK;
          end
          send_random(steer);
          random_sent++;
          run_len++;
          if (fill_est == target) extra--;
        end
        r = $urandom_range(0, 99);
        if (r < 25) target = 0;
        else if (r < 50) target = CAPACITY;
        else target = $urandom_range(1, CAPACITY - 1);
      end
      // mixes change only with nothing in flight
      drain_results();
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (outcomes_pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d requests under four idle/stall mixes, every kind incl. no-ops.",
             requests_sent);
    $display("Full-list rejections: %0d, times the list was emptied: %0d.",
             full_rejects, empty_visits);
    if (mismatches == 0 && outcomes_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outcomes_pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
